>>> src/mbps_pkg.sv
package mbps_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int ADDRESS_BITS        = 48;
   localparam int COUNT_BITS          = 32;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int CSR_DATA_BITS       = 64;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_WILDCARD     = 3'd2,
      CSR_LENGTH       = 3'd3,
      CSR_COUNT_MODE   = 3'd4
   } csr_index_type;

   typedef enum logic {
      KIND_MATCH   = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [7:0]              data_byte;
      logic [ADDRESS_BITS-1:0] byte_address;
      logic                    restart;
      logic                    span_end;
   } req_type;

   typedef struct packed {
      result_kind_type         result_kind;
      logic [ADDRESS_BITS-1:0] match_address;
      logic                    found;
      logic [COUNT_BITS-1:0]   match_count;
      logic                    last_result;
   } rsp_type;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] wildcard_mask;
      logic [4:0]  pattern_length;
      logic        count_mode;
   } cfg_type;

   typedef struct packed {
      logic                    has_match;
      logic                    has_summary;
      logic [ADDRESS_BITS-1:0] match_address;
      logic [ADDRESS_BITS-1:0] summary_address;
      logic                    summary_found;
      logic [COUNT_BITS-1:0]   match_count;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] pattern_byte(cfg_type cfg, int i);
      logic [7:0] b;
      b = 8'd0;
      if (i < 8) begin
         b = cfg.pattern_low[{i[2:0], 3'b000} +: 8];
      end else if (i < 16) begin
         b = cfg.pattern_high[{i[2:0], 3'b000} +: 8];
      end
      return b;
   endfunction

   function automatic logic pattern_wild(cfg_type cfg, int i);
      logic w;
      w = 1'b0;
      if (i < 16) begin
         w = cfg.wildcard_mask[i[3:0]];
      end
      return w;
   endfunction

endpackage

>>> src/mbps_front.sv
module mbps_front #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mbps_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mbps_pkg::req_type          req_data,
   input  mbps_pkg::queue_status_type queue_status,
   output logic                       push,
   output mbps_pkg::entry_type        push_entry
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int AW    = mbps_pkg::ADDRESS_BITS;
   localparam int CW    = mbps_pkg::COUNT_BITS;

   logic [7:0]       window_ff [MAX_PATTERN];
   logic [7:0]       window_in [MAX_PATTERN];
   logic [LEN_W-1:0] fill_ff;
   logic [LEN_W-1:0] fill_in;
   logic             found_ff;
   logic             found_in;
   logic [AW-1:0]    first_ff;
   logic [AW-1:0]    first_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   logic             accept;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] fill_base;
   logic [LEN_W-1:0] fill_item;
   logic [LEN_W-1:0] k;
   logic             hit;
   logic             do_match;
   logic [AW-1:0]    start;
   logic             found_m;
   logic [AW-1:0]    first_m;
   logic [CW-1:0]    count_m;

   always_comb begin
      accept    = req_valid && !queue_status.full;
      req_stall = queue_status.full;

      if (cfg.pattern_length == 5'd0) begin
         eff_len = LEN_W'(1);
      end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = LEN_W'(cfg.pattern_length);
      end

      fill_base = req_data.restart ? '0 : fill_ff;
      if (int'(fill_base) < MAX_PATTERN) begin
         fill_item = fill_base + LEN_W'(1);
      end else begin
         fill_item = fill_base;
      end

      window_in[0] = req_data.data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end

      hit = 1'b1;
      k   = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (i < int'(eff_len)) begin
            k = eff_len - LEN_W'(1) - LEN_W'(i);
            if (!mbps_pkg::pattern_wild(cfg, i) &&
                mbps_pkg::pattern_byte(cfg, i) != window_in[k[IDX_W-1:0]]) begin
               hit = 1'b0;
            end
         end
      end

      do_match = (fill_item >= eff_len) && (cfg.count_mode || !found_ff) && hit;
      start    = req_data.byte_address - AW'(eff_len) + AW'(1);

      found_m = found_ff || do_match;
      first_m = (do_match && !found_ff) ? start : first_ff;
      count_m = (do_match && count_ff != '1) ? count_ff + CW'(1) : count_ff;

      push                       = accept && (do_match || req_data.span_end);
      push_entry.has_match       = do_match;
      push_entry.has_summary     = req_data.span_end;
      push_entry.match_address   = start;
      push_entry.summary_address = first_m;
      push_entry.summary_found   = found_m;
      push_entry.match_count     = count_m;

      fill_in  = fill_ff;
      found_in = found_ff;
      first_in = first_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_data.span_end) begin
            fill_in  = '0;
            found_in = 1'b0;
            first_in = '0;
            count_in = '0;
         end else begin
            fill_in  = fill_item;
            found_in = found_m;
            first_in = first_m;
            count_in = count_m;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         found_ff <= 1'b0;
         first_ff <= '0;
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         found_ff <= found_in;
         first_ff <= first_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/mbps_queue.sv
module mbps_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mbps_pkg::entry_type        push_entry,
   input  logic                       pop,
   output mbps_pkg::entry_type        head_entry,
   output mbps_pkg::queue_status_type queue_status
);

   localparam int DEPTH = mbps_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbps_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   always_comb begin
      queue_status.full  = (count_ff == CNT_W'(DEPTH));
      queue_status.empty = (count_ff == '0);
      head_entry         = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/mbps_back.sv
module mbps_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mbps_pkg::entry_type        head_entry,
   input  mbps_pkg::queue_status_type queue_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mbps_pkg::rsp_type          rsp_data
);

   logic              phase_ff;
   logic              phase_in;
   logic              valid_ff;
   logic              valid_in;
   mbps_pkg::rsp_type data_ff;
   mbps_pkg::rsp_type data_in;
   logic              load;

   always_comb begin
      load     = (!valid_ff || !rsp_stall) && !queue_status.empty;
      pop      = 1'b0;
      phase_in = phase_ff;
      data_in  = data_ff;
      valid_in = valid_ff && rsp_stall;

      if (load) begin
         valid_in = 1'b1;
         if (head_entry.has_match && !phase_ff) begin
            data_in.result_kind   = mbps_pkg::KIND_MATCH;
            data_in.match_address = head_entry.match_address;
            data_in.found         = 1'b1;
            data_in.match_count   = head_entry.match_count;
            data_in.last_result   = !head_entry.has_summary;
            if (head_entry.has_summary) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            data_in.result_kind   = mbps_pkg::KIND_SUMMARY;
            data_in.match_address = head_entry.summary_address;
            data_in.found         = head_entry.summary_found;
            data_in.match_count   = head_entry.match_count;
            data_in.last_result   = 1'b1;
            phase_in              = 1'b0;
            pop                   = 1'b1;
         end
      end

      rsp_valid = valid_ff;
      rsp_data  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> src/masked_byte_pattern_scanner.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    mbps_pkg::req_type, one byte per transaction
// rsp_      out        rsp_valid/stall    mbps_pkg::rsp_type, up to two per byte
// csr_      in         csr_write_enable   csr_index, csr_write_data
//
// Takes one byte per cycle unless stalled; the window compare and span statistics
// finish in the cycle the byte is accepted. A byte with a match and a span end gives
// two results; a four-entry queue between scan and output absorbs these bursts.
// Results pass the queue, then the output register. Reset is synchronous, active
// high. A stalled rsp_ side fills the queue, and req_stall rises once it is full.
module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mbps_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mbps_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   mbps_pkg::cfg_type          cfg_ff;
   mbps_pkg::cfg_type          cfg_in;
   mbps_pkg::queue_status_type queue_status;
   mbps_pkg::entry_type        push_entry;
   mbps_pkg::entry_type        head_entry;
   logic                       push;
   logic                       pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mbps_pkg::CSR_PATTERN_LOW:  cfg_in.pattern_low    = csr_write_data;
            mbps_pkg::CSR_PATTERN_HIGH: cfg_in.pattern_high   = csr_write_data;
            mbps_pkg::CSR_WILDCARD:     cfg_in.wildcard_mask  = csr_write_data[15:0];
            mbps_pkg::CSR_LENGTH:       cfg_in.pattern_length = csr_write_data[4:0];
            mbps_pkg::CSR_COUNT_MODE:   cfg_in.count_mode     = csr_write_data[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.wildcard_mask  <= '0;
         cfg_ff.pattern_length <= 5'd1;
         cfg_ff.count_mode     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbps_front #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_status(queue_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   mbps_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .pop         (pop),
      .head_entry  (head_entry),
      .queue_status(queue_status)
   );

   mbps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .queue_status(queue_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
